/* rtl/iq_instantaneous_features_assert.svh */
// Assertion macros shared by the RTL of the instantaneous feature block.
`ifndef IQ_INSTANTANEOUS_FEATURES_ASSERT_SVH
`define IQ_INSTANTANEOUS_FEATURES_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication under the async reset.
`define IFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication under the async reset.
`define IFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define IFC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define IFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/ifc_pkg.sv */
// Shared types, constants and the arctangent table of the feature block.
package ifc_pkg;

	localparam int GUARD_BITS = 14;
	localparam int MAX_STAGES = 24;
	localparam logic [16:0] INV_GAIN_Q17 = 17'd79594;
	localparam int MAG_SHIFT = GUARD_BITS + 17;

	// Magnitude and phase of one vector from the CORDIC core.
	typedef struct packed {
		logic [15:0]        mag;
		logic signed [15:0] phase;
	} vec_res_t;

	// Arctangent of 2^-idx in units of 2^-32 turn, rounded.
	function automatic logic [31:0] atan_turns(input logic [4:0] idx);
		logic [31:0] a;
		unique case (idx)
			5'd0:  a = 32'h20000000;
			5'd1:  a = 32'h12E4051E;
			5'd2:  a = 32'h09FB385B;
			5'd3:  a = 32'h051111D4;
			5'd4:  a = 32'h028B0D43;
			5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E;
			5'd7:  a = 32'h00517C55;
			5'd8:  a = 32'h0028BE53;
			5'd9:  a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2FA;
			5'd15: a = 32'h0000517D;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30;
			5'd19: a = 32'h00000518;
			5'd20: a = 32'h0000028C;
			5'd21: a = 32'h00000146;
			5'd22: a = 32'h000000A3;
			5'd23: a = 32'h00000051;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage

/* rtl/ifc_cordic.sv */
// Iterative CORDIC vectoring core with a shared split constant multiplier.
module ifc_cordic #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [SAMPLE_WIDTH-1:0] i_in,
	input  logic signed [SAMPLE_WIDTH-1:0] q_in,
	output logic                           done,
	output ifc_pkg::vec_res_t              res
);

	localparam int N  = (CORDIC_ITERATIONS > ifc_pkg::MAX_STAGES) ?
		ifc_pkg::MAX_STAGES : CORDIC_ITERATIONS;
	localparam int CW = $clog2(N);
	localparam int XW = SAMPLE_WIDTH + 17;
	localparam int XU = XW - 1;
	localparam int H  = (XU + 1) / 2;
	localparam int PW = H + 17;
	localparam int AW = XU + 17;

	typedef enum logic [4:0] {
		C_IDLE   = 5'b00001,
		C_ITER   = 5'b00010,
		C_MUL_LO = 5'b00100,
		C_MUL_HI = 5'b01000,
		C_ROUND  = 5'b10000
	} cstate_t;

	cstate_t               state_q;
	logic [CW-1:0]         cnt_q;
	logic signed [XW-1:0]  x_q, y_q;
	logic [31:0]           z_q;
	logic                  zero_q;
	logic [AW-1:0]         acc_q;
	logic                  done_q;
	ifc_pkg::vec_res_t     res_q;

	logic signed [XW-1:0]  x_init, y_init, dx, dy;
	logic [31:0]           atan_v;
	logic [H-1:0]          mul_op;
	logic [PW-1:0]         prod;
	logic [AW:0]           rnd_sum, mag_wide;
	logic [31:0]           z_rnd;

	// Scale the sample by the guard bits.
	assign x_init = {{3{i_in[SAMPLE_WIDTH-1]}}, i_in, {ifc_pkg::GUARD_BITS{1'b0}}};
	assign y_init = {{3{q_in[SAMPLE_WIDTH-1]}}, q_in, {ifc_pkg::GUARD_BITS{1'b0}}};

	// Shared micro-rotation step.
	assign dx     = y_q >>> cnt_q;
	assign dy     = x_q >>> cnt_q;
	assign atan_v = ifc_pkg::atan_turns(5'(cnt_q));

	// One multiplier serves both halves of the final x.
	assign mul_op = (state_q == C_MUL_LO) ? x_q[H-1:0] : H'(x_q[XU-1:H]);
	assign prod   = PW'(mul_op) * PW'(ifc_pkg::INV_GAIN_Q17);

	// Rounding of magnitude and phase.
	assign rnd_sum  = {1'b0, acc_q} + ((AW+1)'(1) << (ifc_pkg::MAG_SHIFT - 1));
	assign mag_wide = rnd_sum >> ifc_pkg::MAG_SHIFT;
	assign z_rnd    = z_q + 32'h0000_8000;

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						zero_q <= (i_in == '0) && (q_in == '0);
						cnt_q  <= '0;
						if (i_in[SAMPLE_WIDTH-1]) begin
							x_q <= -x_init;
							y_q <= -y_init;
							z_q <= 32'h8000_0000;
						end else begin
							x_q <= x_init;
							y_q <= y_init;
							z_q <= 32'h0000_0000;
						end
						state_q <= C_ITER;
					end
				end
				C_ITER: begin
					if (!y_q[XW-1]) begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + atan_v;
					end else begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - atan_v;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(N - 1)) begin
						state_q <= C_MUL_LO;
					end
				end
				C_MUL_LO: begin
					acc_q   <= AW'(prod);
					state_q <= C_MUL_HI;
				end
				C_MUL_HI: begin
					acc_q   <= acc_q + (AW'(prod) << H);
					state_q <= C_ROUND;
				end
				C_ROUND: begin
					res_q.mag   <= (mag_wide > (AW+1)'(16'hFFFF)) ? 16'hFFFF : mag_wide[15:0];
					res_q.phase <= zero_q ? 16'sd0 : z_rnd[31:16];
					done_q      <= 1'b1;
					state_q     <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

	`include "iq_instantaneous_features_assert.svh"

	`IFC_ASSERT_NOW(a_start_idle, clk, arst_n, start, state_q == C_IDLE)
	`IFC_ASSERT_NEXT(a_iter_exit, clk, arst_n, (state_q == C_ITER) && (cnt_q == CW'(N - 1)), state_q == C_MUL_LO)
	`IFC_ASSERT_NEXT(a_round_done, clk, arst_n, state_q == C_ROUND, done_q && (state_q == C_IDLE))

endmodule

/* rtl/iq_instantaneous_features.sv */
// Top level: instantaneous magnitude, phase and frequency of an I/Q sample stream.
// Usage:
//   Input channel in_valid/in_ready carries one I/Q sample per item with a
//   last_sample flag that closes the frame. Output channel out_valid/out_ready
//   carries results: magnitude, phase, frequency and frame_end.
//   Each sample is reported when the next one arrives, with frequency equal to
//   the wrapped phase step to that sample. The last sample of a frame is then
//   reported on its own with frequency zero and frame_end set.
//   An item passes from acceptance to its first result being loaded through
//   these steps: one micro-rotation per cycle in the shared CORDIC step unit,
//   the low and high halves of x on the split gain multiplier, the rounding
//   step, the hand-off of the result to the frame sequencer and the load of
//   the output register.
//   in_ready is high only while the block is idle. A waiting result sits in
//   the output register; the block still accepts the next item, and stalls
//   only when a new result needs that register. Reset and the close of a
//   frame clear the held sample, so a frame's first sample gives no result
//   of its own unless it also ends the frame.
module iq_instantaneous_features #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
	input  logic signed [SAMPLE_WIDTH-1:0] q_sample,
	input  logic                           last_sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [15:0]                    magnitude,
	output logic signed [15:0]             phase,
	output logic signed [15:0]             frequency,
	output logic                           frame_end
);

	typedef enum logic [3:0] {
		S_IDLE      = 4'b0001,
		S_BUSY      = 4'b0010,
		S_EMIT_PREV = 4'b0100,
		S_EMIT_LAST = 4'b1000
	} state_t;

	state_t              state_q;
	logic                last_q;
	logic                have_prev_q;
	logic [15:0]         prev_mag_q;
	logic signed [15:0]  prev_phase_q;
	logic                out_valid_q;
	logic [15:0]         mag_q;
	logic signed [15:0]  phase_q;
	logic signed [15:0]  freq_q;
	logic                frame_end_q;

	logic                start;
	logic                core_done;
	ifc_pkg::vec_res_t   core_res;
	logic                slot_free;
	logic                load_out;

	assign in_ready  = (state_q == S_IDLE);
	assign start     = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign load_out  = slot_free && ((state_q == S_EMIT_PREV) || (state_q == S_EMIT_LAST));

	ifc_cordic #(
		.SAMPLE_WIDTH      (SAMPLE_WIDTH),
		.CORDIC_ITERATIONS (CORDIC_ITERATIONS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.i_in   (i_sample),
		.q_in   (q_sample),
		.done   (core_done),
		.res    (core_res)
	);

	// Frame sequencing, held sample and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			last_q       <= 1'b0;
			have_prev_q  <= 1'b0;
			prev_mag_q   <= '0;
			prev_phase_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						last_q  <= last_sample;
						state_q <= S_BUSY;
					end
				end
				S_BUSY: begin
					if (core_done) begin
						if (have_prev_q) begin
							state_q <= S_EMIT_PREV;
						end else if (last_q) begin
							state_q <= S_EMIT_LAST;
						end else begin
							prev_mag_q   <= core_res.mag;
							prev_phase_q <= core_res.phase;
							have_prev_q  <= 1'b1;
							state_q      <= S_IDLE;
						end
					end
				end
				S_EMIT_PREV: begin
					if (slot_free) begin
						mag_q       <= prev_mag_q;
						phase_q     <= prev_phase_q;
						freq_q      <= core_res.phase - prev_phase_q;
						frame_end_q <= 1'b0;
						out_valid_q <= 1'b1;
						if (last_q) begin
							state_q <= S_EMIT_LAST;
						end else begin
							prev_mag_q   <= core_res.mag;
							prev_phase_q <= core_res.phase;
							have_prev_q  <= 1'b1;
							state_q      <= S_IDLE;
						end
					end
				end
				S_EMIT_LAST: begin
					if (slot_free) begin
						mag_q        <= core_res.mag;
						phase_q      <= core_res.phase;
						freq_q       <= 16'sd0;
						frame_end_q  <= 1'b1;
						out_valid_q  <= 1'b1;
						have_prev_q  <= 1'b0;
						prev_mag_q   <= '0;
						prev_phase_q <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign magnitude = mag_q;
	assign phase     = phase_q;
	assign frequency = freq_q;
	assign frame_end = frame_end_q;

	`include "iq_instantaneous_features_assert.svh"

	`IFC_ASSERT_NOW(a_done_when_busy, clk, arst_n, core_done, state_q == S_BUSY)
	`IFC_ASSERT_NEXT(a_accept_busy, clk, arst_n, start, !in_ready)
	`IFC_ASSERT_NEXT(a_last_clears, clk, arst_n, load_out && (state_q == S_EMIT_LAST), out_valid_q && frame_end_q && !have_prev_q)

endmodule
